>>> rtl/rotary_encoder_interface_top_assert.svh
// Assertion macros used by the rotary encoder interface RTL.
`ifndef ROTARY_ENCODER_INTERFACE_TOP_ASSERT_SVH
`define ROTARY_ENCODER_INTERFACE_TOP_ASSERT_SVH

// Checks a property on every rising edge of clk_i outside reset.
`define REI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a condition never holds on a rising edge of clk_i outside reset.
`define REI_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> rtl/rei_pkg.sv
// Types, constants and helper functions of the rotary encoder interface.
package rei_pkg;

  localparam int unsigned STEP_COUNT_WIDTH = 8;
  localparam int unsigned QUEUE_DEPTH      = 4;
  localparam int unsigned QPTR_W           = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W           = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IN_TDATA_W       = 40;
  localparam int unsigned OUT_TDATA_W      = 8;

  localparam logic [STEP_COUNT_WIDTH-1:0] STEP_MAX = '1;

  localparam logic [7:0] HIST_MASK    = 8'b1100_0011;
  localparam logic [7:0] HIST_RELEASE = 8'b0000_0011;
  localparam logic [7:0] HIST_PRESS   = 8'b1100_0000;
  localparam logic [7:0] HIST_ALL_UP  = 8'b1111_1111;
  localparam logic [7:0] HIST_ALL_DN  = 8'b0000_0000;

  localparam logic [15:0] LONG_PRESS_RESET = 16'd250;
  localparam logic [1:0]  PAIR_DETENT      = 2'b11;

  localparam logic REQ_ENCODER = 1'b0;
  localparam logic REQ_BUTTON  = 1'b1;

  localparam logic [1:0] EV_PLUS  = 2'd0;
  localparam logic [1:0] EV_MINUS = 2'd1;
  localparam logic [1:0] EV_SHORT = 2'd2;
  localparam logic [1:0] EV_LONG  = 2'd3;

  typedef enum logic [2:0] {
    PH_UP        = 3'b001,
    PH_DOWN      = 3'b010,
    PH_DOWN_LONG = 3'b100
  } phase_e;

  typedef struct packed {
    logic        is_button;
    logic        is_detent;
    logic [1:0]  pair;
    logic        level;
    logic [31:0] now_ms;
  } cmd_t;

  // Gray-code successor in the plus direction: 3, 1, 0, 2, 3.
  function automatic logic [1:0] plus_next(input logic [1:0] p);
    logic [1:0] n;
    case (p)
      2'd0:    n = 2'd2;
      2'd1:    n = 2'd0;
      2'd2:    n = 2'd3;
      default: n = 2'd1;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/rei_front.sv
// Front stage: accepts input beats, classifies them and registers a command.
module rei_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [rei_pkg::IN_TDATA_W-1:0] s_axis_tdata_i,
  input  logic                         s_axis_tuser_i,
  output logic                         cmd_valid_o,
  input  logic                         cmd_ready_i,
  output rei_pkg::cmd_t                cmd_o
);
  import rei_pkg::*;

  logic cmd_valid_q, cmd_valid_d;
  cmd_t cmd_q, cmd_d;
  logic take;

  assign s_axis_tready_o = !cmd_valid_q || cmd_ready_i;
  assign take            = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    cmd_d       = cmd_q;
    cmd_valid_d = cmd_valid_q;
    if (take) begin
      cmd_valid_d     = 1'b1;
      cmd_d.is_button = (s_axis_tuser_i == REQ_BUTTON);
      cmd_d.pair      = s_axis_tdata_i[1:0] == 2'b00 ? 2'b00 :
                        {s_axis_tdata_i[0], s_axis_tdata_i[1]};
      cmd_d.is_detent = (s_axis_tuser_i == REQ_ENCODER) &&
                        (s_axis_tdata_i[1:0] == PAIR_DETENT);
      cmd_d.level     = s_axis_tdata_i[2];
      cmd_d.now_ms    = s_axis_tdata_i[34:3];
    end else if (cmd_ready_i) begin
      cmd_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else begin
      cmd_valid_q <= cmd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = cmd_valid_q;
  assign cmd_o       = cmd_q;

endmodule

>>> rtl/rei_queue.sv
// Short command queue between the front and back stages.
module rei_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rei_pkg::cmd_t in_cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rei_pkg::cmd_t out_cmd_o
);
  import rei_pkg::*;

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push, pop;

  assign in_ready_o  = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign out_valid_o = (count_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_cmd_i;
    end
  end

endmodule

>>> rtl/rei_back.sv
// Back stage: encoder and button state, event generation and output register.
module rei_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  rei_pkg::cmd_t cmd_i,
  input  logic [15:0]   long_press_ms_i,
  output logic          evt_valid_o,
  input  logic          evt_ready_i,
  output logic [1:0]    evt_kind_o
);
  import rei_pkg::*;

  logic [1:0]                  last_q, last_d;
  logic [STEP_COUNT_WIDTH-1:0] plus_q, plus_d, minus_q, minus_d, plus_n, minus_n;
  logic [7:0]                  hist_q, hist_d, hist_n, hist_m;
  phase_e                      phase_q, phase_d;
  logic [31:0]                 start_q, start_d, held;
  logic                        out_valid_q, out_valid_d;
  logic [1:0]                  out_kind_q, out_kind_d;
  logic                        exec, emit;
  logic [1:0]                  kind;

  assign cmd_ready_o = !out_valid_q || evt_ready_i;
  assign exec        = cmd_valid_i && cmd_ready_o;

  always_comb begin
    last_d  = last_q;
    plus_d  = plus_q;
    minus_d = minus_q;
    hist_d  = hist_q;
    phase_d = phase_q;
    start_d = start_q;
    plus_n  = plus_q;
    minus_n = minus_q;
    hist_n  = {hist_q[6:0], cmd_i.level};
    hist_m  = hist_n & HIST_MASK;
    held    = '0;
    emit    = 1'b0;
    kind    = EV_PLUS;
    if (exec && !cmd_i.is_button) begin
      if (cmd_i.pair == plus_next(last_q)) begin
        if (plus_q != STEP_MAX) plus_n = plus_q + 1'b1;
      end else if (last_q == plus_next(cmd_i.pair)) begin
        if (minus_q != STEP_MAX) minus_n = minus_q + 1'b1;
      end
      last_d = cmd_i.pair;
      if (cmd_i.is_detent) begin
        if (plus_n > minus_n) begin
          emit = 1'b1;
          kind = EV_PLUS;
        end else if (plus_n < minus_n) begin
          emit = 1'b1;
          kind = EV_MINUS;
        end
        plus_d  = '0;
        minus_d = '0;
      end else begin
        plus_d  = plus_n;
        minus_d = minus_n;
      end
    end else if (exec) begin
      hist_d = hist_n;
      if (hist_m == HIST_RELEASE) begin
        hist_d = HIST_ALL_UP;
        if (phase_q == PH_DOWN) begin
          emit = 1'b1;
          kind = EV_SHORT;
        end
        phase_d = PH_UP;
      end else if (hist_m == HIST_PRESS) begin
        hist_d  = HIST_ALL_DN;
        phase_d = PH_DOWN;
        start_d = cmd_i.now_ms;
      end
      held = cmd_i.now_ms - start_d;
      if (phase_d == PH_DOWN && !emit && held > {16'd0, long_press_ms_i}) begin
        phase_d = PH_DOWN_LONG;
        emit    = 1'b1;
        kind    = EV_LONG;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_kind_d  = out_kind_q;
    if (exec && emit) begin
      out_valid_d = 1'b1;
      out_kind_d  = kind;
    end else if (evt_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= PAIR_DETENT;
      plus_q      <= '0;
      minus_q     <= '0;
      hist_q      <= HIST_ALL_UP;
      phase_q     <= PH_UP;
      start_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      last_q      <= last_d;
      plus_q      <= plus_d;
      minus_q     <= minus_d;
      hist_q      <= hist_d;
      phase_q     <= phase_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q <= out_kind_d;
  end

  assign evt_valid_o = out_valid_q;
  assign evt_kind_o  = out_kind_q;

`include "rotary_encoder_interface_top_assert.svh"

  `REI_ASSERT(a_detent_clears, exec && !cmd_i.is_button && cmd_i.is_detent |=> plus_q == '0 && minus_q == '0, "step counters not cleared at detent")
  `REI_ASSERT(a_no_long_from_up, phase_q == PH_UP |=> phase_q != PH_DOWN_LONG, "long hold reached without a press")
  `REI_ASSERT(a_short_ends_up, exec && emit && kind == EV_SHORT |=> phase_q == PH_UP, "short click left the button down")
  `REI_ASSERT_NEVER(a_stalled_exec, exec && out_valid_q && !evt_ready_i, "command executed over a waiting event")

endmodule

>>> rtl/rotary_encoder_interface_top.sv
// Rotary encoder interface: quadrature decoding and push-button click detection.
// Input stream: one beat per encoder sample or button tick. tuser selects the
// kind (0 encoder sample, 1 button tick); tdata carries phase levels, switch
// level and the millisecond time stamp.
// Output stream: one beat per turn or click event, event kind in tdata.
// Configuration: cfg_valid_i/cfg_ready_o load the long press time in ms;
// cfg_ready_o is always high and the value is used from the next beat on.
// Path: the edge that accepts an input beat loads the front register, and
// its event reaches the output through the queue and the event register.
// Throughput: one input beat per cycle while the receiver does not stall; the
// back stage updates its state once per cycle for each queued command.
// Reset clears the encoder to the detent state with empty counters, the
// button to released and the long press time to 250 ms.
// When the receiver stalls, the event register holds its beat, the back stage
// stops, the four-entry queue and front register fill, and then tready drops.
module rotary_encoder_interface_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // phase_a [0], phase_b [1], switch_level [2], now_ms [34:3], zero [39:35]
  input  logic [rei_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // req_type [0]
  input  logic                          s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // event_kind [1:0], zero [7:2]
  output logic [rei_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [15:0]                   cfg_data_i
);
  import rei_pkg::*;

  logic        f_valid, f_ready, q_valid, q_ready;
  cmd_t        f_cmd, q_cmd;
  logic [15:0] long_press_q;
  logic [1:0]  evt_kind;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q <= LONG_PRESS_RESET;
    end else if (cfg_valid_i) begin
      long_press_q <= cfg_data_i;
    end
  end

  rei_front u_front (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  rei_queue u_queue (
    .clk_i,
    .rst_ni,
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_cmd_i    (f_cmd),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_cmd_o   (q_cmd)
  );

  rei_back u_back (
    .clk_i,
    .rst_ni,
    .cmd_valid_i     (q_valid),
    .cmd_ready_o     (q_ready),
    .cmd_i           (q_cmd),
    .long_press_ms_i (long_press_q),
    .evt_valid_o     (m_axis_tvalid_o),
    .evt_ready_i     (m_axis_tready_i),
    .evt_kind_o      (evt_kind)
  );

  assign m_axis_tdata_o = {(OUT_TDATA_W - 2)'(0), evt_kind};

endmodule
